### hw/rtl/sac_pkg.sv
// package for the set associative cache with lru replacement
// holds sizes, register indexes and the cache entry layout
// no dependencies
package sac_pkg;

  localparam int SETS     = 64;
  localparam int WAYS     = 8;
  localparam int ENTRIES  = SETS * WAYS;
  localparam int SET_W    = 6;
  localparam int WAY_W    = 3;
  localparam int ENT_W    = SET_W + WAY_W;
  localparam int SCNT_W   = 7;
  localparam int WCNT_W   = 4;
  localparam int ADDR_W   = 32;
  localparam int AGE_W    = 32;
  localparam int MOD_STEPS = ADDR_W;
  localparam int STEP_W   = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int OUT_DATA_W = 16;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_SETS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS = 1'b1;

  localparam logic [SCNT_W-1:0] SETS_RST = SCNT_W'(SETS);
  localparam logic [WCNT_W-1:0] WAYS_RST = WCNT_W'(WAYS);

  typedef struct packed {
    logic              valid;
    logic [AGE_W-1:0]  age;
    logic [ADDR_W-1:0] tag;
  } entry_t;

endpackage

### hw/rtl/sac_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/set_assoc_cache_lru_hit_miss.sv
// top level of the set associative cache with lru replacement
// depends on sac_pkg and sac_ram
//
// channel  direction  word                                     handshake
// in_      slave      block_address                            tvalid/tready
// out_     master     hit, set_index, way_index                tvalid/tready
// cfg_     slave      register index, data                     valid/ready
//
// one address passes through the bit-serial modulo, the pipelined way reads,
// one fill write (held while a result waits) and a return to idle
// after reset a clearing pass walks all 512 entries, one per cycle
// the result register lets the next address enter while a result waits
// cfg writes are always taken
module set_assoc_cache_lru_hit_miss (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // block_address[31:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sac_pkg::OUT_DATA_W-1:0]  out_tdata,  // zero fill, way_index[2:0], set_index[5:0], hit
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sac_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t state_r;

  logic [sac_pkg::SCNT_W-1:0] sets_cfg_r;
  logic [sac_pkg::WCNT_W-1:0] ways_cfg_r;
  logic [sac_pkg::SCNT_W-1:0] nsets_r;
  logic [sac_pkg::WCNT_W-1:0] nways_r;
  logic [sac_pkg::ADDR_W-1:0] addr_r;
  logic [sac_pkg::ADDR_W-1:0] sh_r;
  logic [sac_pkg::SCNT_W-1:0] rem_r;
  logic [sac_pkg::STEP_W-1:0] step_r;
  logic [sac_pkg::ENT_W-1:0]  clr_r;
  logic [sac_pkg::WCNT_W-1:0] rd_w_r;
  logic                       hit_r;
  logic [sac_pkg::WAY_W-1:0]  hit_way_r;
  logic                       empty_r;
  logic [sac_pkg::WAY_W-1:0]  empty_way_r;
  logic [sac_pkg::AGE_W-1:0]  best_r;
  logic [sac_pkg::WAY_W-1:0]  best_way_r;
  logic                       out_valid_r;
  logic [sac_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [sac_pkg::SCNT_W-1:0] nsets_nxt;
  logic [sac_pkg::WCNT_W-1:0] nways_nxt;
  logic [sac_pkg::SCNT_W-1:0] rem_t;
  logic [sac_pkg::SCNT_W-1:0] rem_nxt;
  logic [sac_pkg::SET_W-1:0]  set_cur;
  logic                       proc;
  logic [sac_pkg::WAY_W-1:0]  pw;
  sac_pkg::entry_t            rd_ent;
  logic [sac_pkg::AGE_W-1:0]  aged;
  logic                       out_free;
  logic [sac_pkg::WAY_W-1:0]  fin_way;

  logic                       ram_we;
  logic [sac_pkg::ENT_W-1:0]  ram_waddr;
  sac_pkg::entry_t            ram_wdata;
  logic [sac_pkg::ENT_W-1:0]  ram_raddr;

  sac_ram #(
    .WIDTH ($bits(sac_pkg::entry_t)),
    .DEPTH (sac_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_ent)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;
  assign set_cur    = rem_r[sac_pkg::SET_W-1:0];

  always_comb begin
    if (sets_cfg_r == '0) begin
      nsets_nxt = sac_pkg::SCNT_W'(1);
    end else if (sets_cfg_r > sac_pkg::SETS_RST) begin
      nsets_nxt = sac_pkg::SETS_RST;
    end else begin
      nsets_nxt = sets_cfg_r;
    end
    if (ways_cfg_r == '0) begin
      nways_nxt = sac_pkg::WCNT_W'(1);
    end else if (ways_cfg_r > sac_pkg::WAYS_RST) begin
      nways_nxt = sac_pkg::WAYS_RST;
    end else begin
      nways_nxt = ways_cfg_r;
    end
  end

  // one restoring step of the modulo
  always_comb begin
    rem_t = {rem_r[sac_pkg::SCNT_W-2:0], sh_r[sac_pkg::ADDR_W-1]};
    if (rem_t >= nsets_r) begin
      rem_nxt = rem_t - nsets_r;
    end else begin
      rem_nxt = rem_t;
    end
  end

  always_comb begin
    proc = (state_r == ST_SCAN) && (rd_w_r != '0);
    pw   = rd_w_r[sac_pkg::WAY_W-1:0] - sac_pkg::WAY_W'(1);
    if (rd_ent.valid && rd_ent.age != sac_pkg::AGE_MAX) begin
      aged = rd_ent.age + sac_pkg::AGE_W'(1);
    end else begin
      aged = rd_ent.age;
    end
    if (hit_r) begin
      fin_way = hit_way_r;
    end else if (empty_r) begin
      fin_way = empty_way_r;
    end else begin
      fin_way = best_way_r;
    end
  end

  always_comb begin
    ram_raddr = {set_cur, rd_w_r[sac_pkg::WAY_W-1:0]};
    ram_we    = 1'b0;
    ram_waddr = {set_cur, pw};
    ram_wdata = '{valid: 1'b1, age: aged, tag: rd_ent.tag};
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      ST_SCAN: begin
        ram_we = proc && rd_ent.valid;
      end
      ST_FIN: begin
        ram_we    = out_free;
        ram_waddr = {set_cur, fin_way};
        ram_wdata = '{valid: 1'b1, age: '0, tag: addr_r};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      sets_cfg_r  <= sac_pkg::SETS_RST;
      ways_cfg_r  <= sac_pkg::WAYS_RST;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          sac_pkg::REG_SETS: sets_cfg_r <= cfg_data;
          sac_pkg::REG_WAYS: ways_cfg_r <= cfg_data[sac_pkg::WCNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + sac_pkg::ENT_W'(1);
          if (clr_r == sac_pkg::ENT_W'(sac_pkg::ENTRIES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            addr_r  <= in_tdata;
            sh_r    <= in_tdata;
            rem_r   <= '0;
            step_r  <= '0;
            nsets_r <= nsets_nxt;
            nways_r <= nways_nxt;
            state_r <= ST_MOD;
          end
        end
        ST_MOD: begin
          rem_r  <= rem_nxt;
          sh_r   <= sh_r << 1;
          step_r <= step_r + sac_pkg::STEP_W'(1);
          if (step_r == sac_pkg::STEP_W'(sac_pkg::MOD_STEPS - 1)) begin
            rd_w_r  <= '0;
            hit_r   <= 1'b0;
            empty_r <= 1'b0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (proc) begin
            if (!hit_r && rd_ent.valid && rd_ent.tag == addr_r) begin
              hit_r     <= 1'b1;
              hit_way_r <= pw;
            end
            if (!empty_r && !rd_ent.valid) begin
              empty_r     <= 1'b1;
              empty_way_r <= pw;
            end
            if (pw == '0 || aged > best_r) begin
              best_r     <= aged;
              best_way_r <= pw;
            end
          end
          if (rd_w_r == nways_r) begin
            state_r <= ST_FIN;
          end else begin
            rd_w_r <= rd_w_r + sac_pkg::WCNT_W'(1);
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {{(sac_pkg::OUT_DATA_W - 1 - sac_pkg::SET_W - sac_pkg::WAY_W){1'b0}},
                            fin_way, set_cur, hit_r};
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_rose_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the fill step");

  a_set_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_FIN) |-> rem_r < nsets_r)
    else $error("set index not below set count");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> rd_w_r <= nways_r)
    else $error("way scan ran past way count");

  a_fin_way: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |-> {1'b0, fin_way} < nways_r)
    else $error("chosen way not below way count");

endmodule
